@@ design/sfb_pkg.sv @@
// Shared constants, codes and types for the biased spherical fold.
`default_nettype none
package sfb_pkg;

  localparam int FRAC_BITS = 16;
  localparam int GAIN_FRAC = 12;
  localparam int DIV_W     = 64;

  // Configuration register indexes
  localparam logic [2:0] REG_INNER_RADIUS_SQ   = 3'd0;
  localparam logic [2:0] REG_OUTER_RADIUS_SQ   = 3'd1;
  localparam logic [2:0] REG_BASE_SCALE        = 3'd2;
  localparam logic [2:0] REG_ABS_BIAS_GAINS    = 3'd3;
  localparam logic [2:0] REG_SQUARE_BIAS_GAINS = 3'd4;
  localparam logic [2:0] REG_ITERATION_WINDOWS = 3'd5;
  localparam logic [2:0] REG_MODE_FLAGS        = 3'd6;
  localparam logic [2:0] REG_COLOR_FACTORS     = 3'd7;

  typedef enum logic [1:0] {
    SEL_NONE  = 2'd0,
    SEL_INNER = 2'd1,
    SEL_OUTER = 2'd2
  } fold_sel_t;

  // Data that rides alongside the divider
  typedef struct packed {
    logic [2:0]  zneg;
    logic [31:0] zmag_x;
    logic [31:0] zmag_y;
    logic [31:0] zmag_z;
    logic        mneg;
    logic [31:0] de;
    logic [31:0] color;
    fold_sel_t   sel;
  } side_t;

endpackage
`default_nettype wire

@@ design/sfb_div.sv @@
// Fully pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sfb_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      en,
  input  wire logic                      in_valid,
  input  wire logic [sfb_pkg::DIV_W-1:0] dividend,
  input  wire logic [sfb_pkg::DIV_W-1:0] divisor,
  input  wire sfb_pkg::side_t            in_side,
  output logic                           out_valid,
  output logic [sfb_pkg::DIV_W-1:0]      quotient,
  output sfb_pkg::side_t                 out_side
);

  localparam int W = sfb_pkg::DIV_W;

  // stage registers; the last stage keeps only quotient, valid and side data
  logic [W-1:0]   rem  [W-1];
  logic [W-1:0]   dq   [W];
  logic [W-1:0]   dsr  [W-1];
  logic           vld  [W];
  sfb_pkg::side_t side [W];

  logic [W-1:0]   rem_in [W];
  logic [W-1:0]   dq_in  [W];
  logic [W-1:0]   dsr_in [W];
  logic [W-1:0]   rem_n  [W];
  logic [W-1:0]   dq_n   [W];

  // stage 0 works on the inputs, stage i on the registers of stage i-1
  always_comb begin
    logic [W:0] rs;
    logic       ge;
    rem_in[0] = '0;
    dq_in[0]  = dividend;
    dsr_in[0] = divisor;
    for (int i = 1; i < W; i++) begin
      rem_in[i] = rem[i-1];
      dq_in[i]  = dq[i-1];
      dsr_in[i] = dsr[i-1];
    end
    for (int i = 0; i < W; i++) begin
      rs = {rem_in[i], dq_in[i][W-1]};
      ge = (rs >= {1'b0, dsr_in[i]});
      rem_n[i] = ge ? W'(rs - {1'b0, dsr_in[i]}) : rs[W-1:0];
      dq_n[i]  = {dq_in[i][W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < W - 1; i++) begin
        rem[i] <= rem_n[i];
        dsr[i] <= dsr_in[i];
      end
      for (int i = 0; i < W; i++) dq[i] <= dq_n[i];
      side[0] <= in_side;
      for (int i = 1; i < W; i++) side[i] <= side[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < W; i++) vld[i] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < W; i++) vld[i] <= vld[i-1];
    end
  end

  assign out_valid = vld[W-1];
  assign quotient  = dq[W-1];
  assign out_side  = side[W-1];

endmodule
`default_nettype wire

@@ design/spherical_fold_biased.sv @@
// Top level: spherical fold with constant-biased inner radius, Q16.16.
// Pipeline: 5 front stages, a 64-stage divider that resolves one quotient bit per
//   stage, 2 multiply stages.
// Throughput: one transaction per cycle; the whole pipe advances together and
//   holds in place while the output is stalled.
// Reset (rst, synchronous): clears all valid bits and loads register defaults.
`default_nettype none
module spherical_fold_biased (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration write port
  input  wire logic         cfg_wen,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [63:0]  cfg_data,
  // input stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // point_x, point_y, point_z, const_x, const_y, const_z, iteration, color_in,
  // distance_in (low to high)
  input  wire logic [271:0] s_tdata,
  // output stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // folded_x, folded_y, folded_z, color_out, distance_out (low to high)
  output logic [159:0]      m_tdata
);

  localparam int FB = sfb_pkg::FRAC_BITS;
  localparam int GF = sfb_pkg::GAIN_FRAC;

  // ---------------- configuration registers ----------------
  logic [31:0] inner_radius_sq, outer_radius_sq, base_scale;
  logic [47:0] abs_bias_gains, square_bias_gains;
  logic [63:0] iteration_windows, color_factors;
  logic [1:0]  mode_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      inner_radius_sq   <= 32'(1) << (FB - 2);
      outer_radius_sq   <= 32'(1) << FB;
      base_scale        <= 32'(1) << FB;
      abs_bias_gains    <= '0;
      square_bias_gains <= '0;
      iteration_windows <= '0;
      mode_flags        <= 2'd2;
      color_factors     <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        sfb_pkg::REG_INNER_RADIUS_SQ:   inner_radius_sq   <= cfg_data[31:0];
        sfb_pkg::REG_OUTER_RADIUS_SQ:   outer_radius_sq   <= cfg_data[31:0];
        sfb_pkg::REG_BASE_SCALE:        base_scale        <= cfg_data[31:0];
        sfb_pkg::REG_ABS_BIAS_GAINS:    abs_bias_gains    <= cfg_data[47:0];
        sfb_pkg::REG_SQUARE_BIAS_GAINS: square_bias_gains <= cfg_data[47:0];
        sfb_pkg::REG_ITERATION_WINDOWS: iteration_windows <= cfg_data;
        sfb_pkg::REG_MODE_FLAGS:        mode_flags        <= cfg_data[1:0];
        sfb_pkg::REG_COLOR_FACTORS:     color_factors     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance: every stage moves when the output slot is free or taken.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- stage 1: unpack, magnitudes, window tests ----------------
  logic [31:0] in_pt [3];
  logic [31:0] in_c  [3];
  logic [15:0] in_it;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_pt[k] = s_tdata[32*k +: 32];
      in_c[k]  = s_tdata[96 + 32*k +: 32];
    end
    in_it = s_tdata[207:192];
  end

  logic        v1;
  logic [31:0] s1_cm [3];
  logic [31:0] s1_zm [3];
  logic [2:0]  s1_zneg;
  logic        s1_win_a, s1_win_b;
  logic [31:0] s1_de, s1_color;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_cm[k]   <= in_c[k][31]  ? 32'(-in_c[k])  : in_c[k];
        s1_zm[k]   <= in_pt[k][31] ? 32'(-in_pt[k]) : in_pt[k];
        s1_zneg[k] <= in_pt[k][31];
      end
      // window holds for start <= it < stop
      s1_win_a <= (in_it >= iteration_windows[15:0]) && (in_it < iteration_windows[31:16]);
      s1_win_b <= mode_flags[0] && (in_it >= iteration_windows[47:32])
                  && (in_it < iteration_windows[63:48]);
      s1_de    <= s_tdata[271:240];
      s1_color <= s_tdata[239:208];
    end
  end

  // ---------------- stage 2: squares and |c| gain products ----------------
  logic               v2;
  logic signed [48:0] s2_absp [3];
  logic [63:0]        s2_csq  [3];
  logic [63:0]        s2_zsq  [3];
  logic [31:0]        s2_zm   [3];
  logic [2:0]         s2_zneg;
  logic               s2_win_a, s2_win_b;
  logic [31:0]        s2_de, s2_color;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s2_absp[k] <= $signed({1'b0, s1_cm[k]}) * $signed(abs_bias_gains[16*k +: 16]);
        s2_csq[k]  <= 64'(s1_cm[k]) * 64'(s1_cm[k]);
        s2_zsq[k]  <= 64'(s1_zm[k]) * 64'(s1_zm[k]);
        s2_zm[k]   <= s1_zm[k];
      end
      s2_zneg  <= s1_zneg;
      s2_win_a <= s1_win_a;
      s2_win_b <= s1_win_b;
      s2_de    <= s1_de;
      s2_color <= s1_color;
    end
  end

  // ---------------- stage 3: c^2 gain products, floor terms, |z|^2 ----------------
  logic               v3;
  logic signed [63:0] s3_abst [3];
  logic signed [63:0] s3_sqt  [3];
  logic [49:0]        s3_rr;
  logic [31:0]        s3_zm   [3];
  logic [2:0]         s3_zneg;
  logic [31:0]        s3_de, s3_color;

  logic signed [64:0] sq_prod [3];
  logic [65:0]        zsq_sum;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_prod[k] = $signed({1'b0, 48'(s2_csq[k] >> FB)})
                   * $signed(square_bias_gains[16*k +: 16]);
    end
    zsq_sum = 66'(s2_zsq[0]) + 66'(s2_zsq[1]) + 66'(s2_zsq[2]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        // arithmetic shift gives the floor rounding
        s3_abst[k] <= s2_win_a ? 64'(s2_absp[k] >>> GF) : '0;
        s3_sqt[k]  <= s2_win_b ? 64'(sq_prod[k] >>> GF) : '0;
        s3_zm[k]   <= s2_zm[k];
      end
      s3_rr    <= 50'(zsq_sum >> FB);
      s3_zneg  <= s2_zneg;
      s3_de    <= s2_de;
      s3_color <= s2_color;
    end
  end

  // ---------------- stage 4: threshold sum and clamp ----------------
  logic               v4;
  logic signed [63:0] s4_thr;
  logic [49:0]        s4_rr;
  logic [31:0]        s4_zm [3];
  logic [2:0]         s4_zneg;
  logic [31:0]        s4_de, s4_color;

  logic signed [63:0] thr_sum;
  logic signed [63:0] outer_s;

  always_comb begin
    outer_s = $signed({32'b0, outer_radius_sq});
    thr_sum = $signed({32'b0, inner_radius_sq})
              + s3_abst[0] + s3_abst[1] + s3_abst[2]
              + s3_sqt[0] + s3_sqt[1] + s3_sqt[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_thr   <= (mode_flags[1] && thr_sum > outer_s) ? outer_s : thr_sum;
      s4_rr    <= s3_rr;
      s4_zm    <= s3_zm;
      s4_zneg  <= s3_zneg;
      s4_de    <= s3_de;
      s4_color <= s3_color;
    end
  end

  // ---------------- stage 5: fold select, dividend and divisor ----------------
  logic                          v5;
  logic [sfb_pkg::DIV_W-1:0]     s5_dividend, s5_divisor;
  sfb_pkg::side_t                s5_side;

  logic [31:0]          base_mag;
  logic                 fold_inner, fold_outer;
  sfb_pkg::fold_sel_t   sel;

  always_comb begin
    base_mag   = base_scale[31] ? 32'(-base_scale) : base_scale;
    fold_inner = (s4_thr > 64'sd0) && ({14'b0, s4_rr} < 64'(s4_thr));
    fold_outer = (s4_rr < 50'(outer_radius_sq));
    priority if (fold_inner) sel = sfb_pkg::SEL_INNER;
    else if (fold_outer)     sel = sfb_pkg::SEL_OUTER;
    else                     sel = sfb_pkg::SEL_NONE;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unique case (sel)
        sfb_pkg::SEL_INNER: begin
          s5_dividend <= 64'(base_mag) * 64'(outer_radius_sq);
          s5_divisor  <= 64'(s4_thr);
        end
        sfb_pkg::SEL_OUTER: begin
          // zero radius divides by one LSB
          s5_dividend <= 64'(base_mag) * 64'(outer_radius_sq);
          s5_divisor  <= (s4_rr == '0) ? 64'd1 : 64'(s4_rr);
        end
        default: begin
          // no fold: pass base magnitude through the divider
          s5_dividend <= 64'(base_mag);
          s5_divisor  <= 64'd1;
        end
      endcase
      s5_side.zneg   <= s4_zneg;
      s5_side.zmag_x <= s4_zm[0];
      s5_side.zmag_y <= s4_zm[1];
      s5_side.zmag_z <= s4_zm[2];
      s5_side.mneg   <= base_scale[31];
      s5_side.de     <= s4_de;
      s5_side.color  <= s4_color;
      s5_side.sel    <= sel;
    end
  end

  // front-stage valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  // ---------------- divider: scale magnitude ----------------
  logic                      dv_valid;
  logic [sfb_pkg::DIV_W-1:0] dv_q;
  sfb_pkg::side_t            dv_side;

  sfb_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v5),
    .dividend  (s5_dividend),
    .divisor   (s5_divisor),
    .in_side   (s5_side),
    .out_valid (dv_valid),
    .quotient  (dv_q),
    .out_side  (dv_side)
  );

  // ---------------- stage M1: partial products (32x32 halves) ----------------
  // lanes 0..2 are the point coordinates, lane 3 is the distance estimate
  logic        vm1;
  logic [63:0] m1_pl [4];
  logic [63:0] m1_ph [4];
  logic [2:0]  m1_neg;
  logic [32:0] m1_color;

  logic [31:0] lane_a [4];
  logic [31:0] color_add;

  always_comb begin
    lane_a[0] = dv_side.zmag_x;
    lane_a[1] = dv_side.zmag_y;
    lane_a[2] = dv_side.zmag_z;
    lane_a[3] = dv_side.de;
    unique case (dv_side.sel)
      sfb_pkg::SEL_INNER: color_add = color_factors[31:0];
      sfb_pkg::SEL_OUTER: color_add = color_factors[63:32];
      default:            color_add = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        m1_pl[k] <= 64'(lane_a[k]) * 64'(dv_q[31:0]);
        m1_ph[k] <= 64'(lane_a[k]) * 64'(dv_q[63:32]);
      end
      for (int k = 0; k < 3; k++) m1_neg[k] <= dv_side.zneg[k] ^ dv_side.mneg;
      m1_color <= 33'(dv_side.color) + 33'(color_add);
    end
  end

  // ---------------- stage M2: combine, truncate, saturate ----------------
  logic [79:0] prod_q [4];
  logic [31:0] fold_out [3];
  logic [31:0] de_out, color_out;
  logic [31:0] de_p;
  logic [32:0] de_sum;

  always_comb begin
    logic [95:0] full;
    logic [79:0] lim;
    for (int k = 0; k < 4; k++) begin
      full      = 96'(m1_pl[k]) + {m1_ph[k], 32'b0};
      prod_q[k] = full[95:16];
    end
    for (int k = 0; k < 3; k++) begin
      lim = m1_neg[k] ? 80'h8000_0000 : 80'h7FFF_FFFF;
      fold_out[k] = (prod_q[k] > lim) ? lim[31:0] : prod_q[k][31:0];
      if (m1_neg[k]) fold_out[k] = 32'(-fold_out[k]);
    end
    de_p      = (prod_q[3] > 80'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod_q[3][31:0];
    de_sum    = 33'(de_p) + (33'(1) << FB);
    de_out    = de_sum[32] ? 32'hFFFF_FFFF : de_sum[31:0];
    color_out = m1_color[32] ? 32'hFFFF_FFFF : m1_color[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {de_out, color_out, fold_out[2], fold_out[1], fold_out[0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vm1      <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (en) begin
      vm1      <= dv_valid;
      m_tvalid <= vm1;
    end
  end

endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for the biased spherical fold: random and directed points checked against a predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int LATENCY   = 71;
  localparam int STALL_MAX = 20000;

  typedef struct packed {
    logic [31:0] distance_in;
    logic [31:0] color_in;
    logic [15:0] iteration;
    logic [31:0] const_z;
    logic [31:0] const_y;
    logic [31:0] const_x;
    logic [31:0] point_z;
    logic [31:0] point_y;
    logic [31:0] point_x;
  } point_t;

  typedef struct packed {
    logic [31:0] distance_out;
    logic [31:0] color_out;
    logic [31:0] folded_z;
    logic [31:0] folded_y;
    logic [31:0] folded_x;
  } fold_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_wen = 1'b0;
  logic [2:0]   cfg_index = sfb_pkg::REG_INNER_RADIUS_SQ;
  logic [63:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [271:0] s_tdata = '0; // point xyz, const xyz, iteration, color, distance (low up)
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;      // folded xyz, color, distance (low up)

  spherical_fold_biased dut (.*);

  always #4 clk = ~clk;

  // Predictor copy of the register file
  logic [31:0] p_inner, p_outer, p_scale;
  logic [47:0] p_again, p_sgain;
  logic [63:0] p_windows, p_colors;
  logic [1:0]  p_mode;

  point_t pending_points[$];
  fold_t  expected_folds[$];
  int     errors = 0;
  bit     idle_enable = 1'b1;
  bit     hold_sender = 1'b0;
  bit     feeding_done = 1'b0;
  bit     in_taken = 1'b0;
  int     quiet_cycles = 0;

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // floor(v * g / 4096), v nonnegative
  function automatic longint gain_term(logic [63:0] v, logic [15:0] g);
    longint gs, hi, lo;
    gs = longint'($signed(g));
    hi = longint'(v >> 12) * gs;
    lo = longint'(v & 64'hFFF) * gs;
    return hi + (lo >>> 12);
  endfunction

  // truncated (a*b) >> 16, saturated to lim
  function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] b, logic [63:0] lim);
    logic [127:0] p;
    p = (128'(a) * 128'(b)) >> sfb_pkg::FRAC_BITS;
    return (p > 128'(lim)) ? lim : p[63:0];
  endfunction

  function automatic fold_t fold_point(point_t pt);
    fold_t       r;
    longint      thr;
    logic [63:0] rr, mmag, add, col, de, c, zm, p, outer;
    logic [31:0] cv[3];
    logic [31:0] zv[3];
    logic [15:0] it, sa, ea, sb, eb;
    bit          mneg, neg;
    cv = '{pt.const_x, pt.const_y, pt.const_z};
    zv = '{pt.point_x, pt.point_y, pt.point_z};
    it = pt.iteration;
    {eb, sb, ea, sa} = p_windows;
    thr = longint'({32'd0, p_inner});
    outer = {32'd0, p_outer};
    mneg = p_scale[31];
    add = '0;
    rr = '0;
    if (it >= sa && it < ea)
      for (int k = 0; k < 3; k++) thr += gain_term(64'(mag(cv[k])), p_again[16*k +: 16]);
    if (p_mode[0] && it >= sb && it < eb)
      for (int k = 0; k < 3; k++) begin
        c = 64'(mag(cv[k]));
        thr += gain_term((c * c) >> sfb_pkg::FRAC_BITS, p_sgain[16*k +: 16]);
      end
    if (p_mode[1] && thr > longint'(outer)) thr = longint'(outer);
    for (int k = 0; k < 3; k++) begin
      zm = 64'(mag(zv[k]));
      rr += zm * zm;
    end
    rr >>= sfb_pkg::FRAC_BITS;
    mmag = 64'(mag(p_scale));
    if (thr > 0 && rr < 64'(thr)) begin
      mmag = (mmag * outer) / 64'(thr);
      add = {32'd0, p_colors[31:0]};
    end else if (rr < outer) begin
      mmag = (mmag * outer) / (rr == 0 ? 64'd1 : rr);
      add = {32'd0, p_colors[63:32]};
    end
    for (int k = 0; k < 3; k++) begin
      neg = zv[k][31] != mneg;
      p = mul_sat(64'(mag(zv[k])), mmag, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
      zm = neg ? -p : p;
      r[32*k +: 32] = zm[31:0];
    end
    col = {32'd0, pt.color_in} + add;
    r.color_out = col > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : col[31:0];
    de = mul_sat(64'(pt.distance_in), mmag, 64'hFFFF_FFFF) + (64'd1 << sfb_pkg::FRAC_BITS);
    r.distance_out = de > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : de[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Input transactions are seen at the rising edge; predict them there
  always @(posedge clk) begin
    in_taken <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready)
      expected_folds.push_back(fold_point(point_t'(s_tdata)));
  end

  // Driver: one transaction per handshake; new data appears at the falling edge
  int send_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_taken) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_enable && $urandom_range(0, 15) == 0) begin
          send_gap = $urandom_range(1, 14);
          s_tvalid <= 1'b0;
        end else if (!hold_sender && pending_points.size() > 0) begin
          s_tdata  <= pending_points.pop_front();
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall bursts
  int recv_gap = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (recv_gap > 0) begin
        recv_gap--;
        m_tready <= 1'b0;
      end else if (idle_enable && $urandom_range(0, 15) == 0) begin
        recv_gap = $urandom_range(1, 14);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    fold_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = fold_t'(m_tdata);
      if (expected_folds.size() == 0) begin
        $display("unexpected result %h at %0t", m_tdata, $time);
        errors++;
      end else begin
        want = expected_folds.pop_front();
        if (got.folded_x != want.folded_x) report_mismatch("folded_x", got.folded_x, want.folded_x);
        if (got.folded_y != want.folded_y) report_mismatch("folded_y", got.folded_y, want.folded_y);
        if (got.folded_z != want.folded_z) report_mismatch("folded_z", got.folded_z, want.folded_z);
        if (got.color_out != want.color_out)
          report_mismatch("color_out", got.color_out, want.color_out);
        if (got.distance_out != want.distance_out)
          report_mismatch("distance_out", got.distance_out, want.distance_out);
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || feeding_done)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > STALL_MAX) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      sfb_pkg::REG_INNER_RADIUS_SQ:   p_inner   = val[31:0];
      sfb_pkg::REG_OUTER_RADIUS_SQ:   p_outer   = val[31:0];
      sfb_pkg::REG_BASE_SCALE:        p_scale   = val[31:0];
      sfb_pkg::REG_ABS_BIAS_GAINS:    p_again   = val[47:0];
      sfb_pkg::REG_SQUARE_BIAS_GAINS: p_sgain   = val[47:0];
      sfb_pkg::REG_ITERATION_WINDOWS: p_windows = val;
      sfb_pkg::REG_MODE_FLAGS:        p_mode    = val[1:0];
      sfb_pkg::REG_COLOR_FACTORS:     p_colors  = val;
      default: ;
    endcase
  endtask

  // wait until all queued points are sent and every result is back
  task automatic drain();
    wait (pending_points.size() == 0 && !s_tvalid);
    @(negedge clk);
    wait (expected_folds.size() == 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_coord(int scale_sel);
    logic [31:0] v;
    v = $urandom;
    case (scale_sel)
      0: v = $signed(v) >>> 15;   // near origin, mostly inner fold
      1: v = $signed(v) >>> 13;
      2: v = $signed(v) >>> 10;
      default: ;
    endcase
    return v;
  endfunction

  function automatic point_t rand_point(logic [15:0] it_max);
    point_t pt;
    int s;
    s = $urandom_range(0, 4);
    pt.point_x = rand_coord(s);
    pt.point_y = rand_coord(s);
    pt.point_z = rand_coord(s);
    s = $urandom_range(0, 4);
    pt.const_x = rand_coord(s);
    pt.const_y = rand_coord(s);
    pt.const_z = rand_coord(s);
    pt.iteration   = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, it_max));
    pt.color_in    = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
    pt.distance_in = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h000F_FFFF);
    return pt;
  endfunction

  function automatic logic [47:0] rand_gains();
    logic [47:0] g;
    for (int k = 0; k < 3; k++) g[16*k +: 16] = $urandom_range(0, 2) == 0 ? 16'($urandom)
                                               : 16'($signed(16'($urandom)) >>> 4);
    return g;
  endfunction

  initial begin
    point_t pt;
    p_inner = 32'h0000_4000; p_outer = 32'h0001_0000; p_scale = 32'h0001_0000;
    p_again = '0; p_sgain = '0; p_windows = '0; p_mode = 2'd2; p_colors = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: defaults, extremes, zero radius, signs, saturation
    pt = '0;
    pending_points.push_back(pt);                              // zero radius
    pt.point_x = 32'h7FFF_FFFF; pt.point_y = 32'h8000_0000; pt.point_z = 32'h8000_0000;
    pt.color_in = 32'hFFFF_FFFF; pt.distance_in = 32'hFFFF_FFFF;
    pending_points.push_back(pt);                              // no fold, saturation
    pt = '0; pt.point_x = 32'h0000_2000; pt.point_y = 32'hFFFF_E000;
    pt.distance_in = 32'hFFFF_FFFF; pt.color_in = 32'hFFFF_FFF0;
    pending_points.push_back(pt);                              // inner fold
    pt.point_x = 32'h0000_8000; pt.point_z = 32'hFFFF_8000;
    pending_points.push_back(pt);                              // outer fold
    pt = '0; pt.point_x = 32'h0000_0001; pt.point_y = 32'hFFFF_FFFF;
    pending_points.push_back(pt);                              // tiny radius
    drain();

    // Register extremes: all gains, windows, square bias, no clamp, negative scale
    write_reg(sfb_pkg::REG_INNER_RADIUS_SQ, 64'hFFFF_FFFF);
    write_reg(sfb_pkg::REG_OUTER_RADIUS_SQ, 64'h1);
    write_reg(sfb_pkg::REG_BASE_SCALE, 64'h8000_0000);
    write_reg(sfb_pkg::REG_ABS_BIAS_GAINS, 64'h8000_7FFF_FFFF);
    write_reg(sfb_pkg::REG_SQUARE_BIAS_GAINS, 64'h7FFF_8000_0001);
    write_reg(sfb_pkg::REG_ITERATION_WINDOWS, 64'hFFFF_0000_FFFF_0000);
    write_reg(sfb_pkg::REG_MODE_FLAGS, 64'd1);
    write_reg(sfb_pkg::REG_COLOR_FACTORS, 64'hFFFF_FFFF_FFFF_FFFF);
    pt = '0; pt.const_x = 32'h8000_0000; pt.const_y = 32'h7FFF_FFFF; pt.const_z = 32'hFFFF_0000;
    pt.point_x = 32'h0000_0100; pt.iteration = 16'd5; pt.distance_in = 32'h0001_0000;
    pending_points.push_back(pt);
    pt.iteration = 16'hFFFF;                                   // outside both windows
    pending_points.push_back(pt);
    pt.point_y = 32'h7FFF_FFFF; pt.iteration = 16'd0;
    pending_points.push_back(pt);
    drain();
    write_reg(sfb_pkg::REG_INNER_RADIUS_SQ, 64'h0);
    write_reg(sfb_pkg::REG_OUTER_RADIUS_SQ, 64'hFFFF_FFFF);
    write_reg(sfb_pkg::REG_BASE_SCALE, 64'h7FFF_FFFF);
    write_reg(sfb_pkg::REG_ABS_BIAS_GAINS, 64'hFFFF_FFFF_FFFF); // negative bias, threshold stays > 0
    write_reg(sfb_pkg::REG_MODE_FLAGS, 64'd3);
    pt = '0; pt.point_z = 32'h0000_0200; pt.const_x = 32'h0100_0000; pt.iteration = 16'd1;
    pt.distance_in = 32'hFFFF_FFFF;
    pending_points.push_back(pt);
    pt.iteration = 16'd9; pt.point_z = 32'hFFFF_0000;
    pending_points.push_back(pt);
    drain();

    // Random phases, each with fresh registers
    for (int phase = 0; phase < 7; phase++) begin
      write_reg(sfb_pkg::REG_INNER_RADIUS_SQ,
                $urandom_range(0, 3) == 0 ? 64'($urandom)
                                          : 64'($urandom_range(0, 32'h0002_0000)));
      write_reg(sfb_pkg::REG_OUTER_RADIUS_SQ,
                $urandom_range(0, 3) == 0 ? 64'($urandom | 1)
                                          : 64'($urandom_range(1, 32'h0004_0000)));
      write_reg(sfb_pkg::REG_BASE_SCALE,
                $urandom_range(0, 3) == 0 ? 64'($urandom)
                                          : 64'($signed(32'($urandom)) >>> 12));
      write_reg(sfb_pkg::REG_ABS_BIAS_GAINS, 64'(rand_gains()));
      write_reg(sfb_pkg::REG_SQUARE_BIAS_GAINS, 64'(rand_gains()));
      write_reg(sfb_pkg::REG_ITERATION_WINDOWS,
                {16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)),
                 16'($urandom_range(0, 40)), 16'($urandom_range(0, 20))});
      write_reg(sfb_pkg::REG_MODE_FLAGS, 64'($urandom_range(0, 3)));
      write_reg(sfb_pkg::REG_COLOR_FACTORS, {$urandom, $urandom});
      if (phase == 6) idle_enable = 1'b0;                      // final stretch at full rate
      for (int n = 0; n < 100; n++) pending_points.push_back(rand_point(16'd45));
      if (phase == 3) begin
        // let the sender wait until the pipe is empty, then resume
        wait (pending_points.size() < 50);
        hold_sender = 1'b1;
        @(negedge clk);
        wait (!s_tvalid && expected_folds.size() == 0);
        @(negedge clk);
        hold_sender = 1'b0;
      end
      drain();
    end

    feeding_done = 1'b1;
    repeat (LATENCY + 10) @(negedge clk);
    if (errors == 0 && expected_folds.size() == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule
`default_nettype wire
